// ===== hw/rtl/grouped_block_bitmap_allocator_macros.svh =====
// Assertion macros for the grouped block bitmap allocator.
// Used by files that carry concurrent checks; they expect clk and rst_n in scope.
`ifndef GROUPED_BLOCK_BITMAP_ALLOCATOR_MACROS_SVH
`define GROUPED_BLOCK_BITMAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication.
`define GBBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GBBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/gbba_pkg.sv =====
// Shared types, codes and constants of the grouped block bitmap allocator.
// No dependencies; the RAM and the top level refer to it by scoped names.
package gbba_pkg;

    // Fixed field widths
    localparam int CMD_W      = 3;
    localparam int BLK_W      = 18;
    localparam int WIDX_W     = 12;
    localparam int WDATA_W    = 32;
    localparam int GIDX_W     = 4;
    localparam int STATUS_W   = 2;
    localparam int GF_W       = 14;
    localparam int BPG_CFG_W  = 14;
    localparam int GC_CFG_W   = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    // Parameter defaults
    localparam int MAX_GROUPS_DEF     = 16;
    localparam int MAX_GROUP_BITS_DEF = 8192;
    localparam int WORD_BITS_DEF      = 32;
    localparam int STORE_WORDS_DEF    = MAX_GROUPS_DEF * (MAX_GROUP_BITS_DEF / WORD_BITS_DEF);

    // Saturation limits
    localparam logic [GF_W-1:0]  GFREE_MAX = '1;
    localparam logic [BLK_W-1:0] TOTAL_MAX = '1;

    // Configuration reset values
    localparam logic                 FDB_RST = 1'b1;
    localparam logic [BPG_CFG_W-1:0] BPG_RST = 14'd8192;
    localparam logic [GC_CFG_W-1:0]  GC_RST  = 5'd1;
    localparam logic [BLK_W-1:0]     TB_RST  = 18'd8193;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC      = 3'd0,
        CMD_FREE       = 3'd1,
        CMD_LOAD_WORD  = 3'd2,
        CMD_LOAD_GROUP = 3'd3,
        CMD_LOAD_TOTAL = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_SPACE = 2'd1,
        STAT_INVALID  = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_DATA_BLOCK = 2'd0,
        CFG_BLOCKS_PER_GROUP = 2'd1,
        CFG_GROUP_COUNT      = 2'd2,
        CFG_TOTAL_BLOCKS     = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_A_GRP,
        ST_A_CHK,
        ST_A_GRANT,
        ST_F_DIV,
        ST_F_WR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [BLK_W-1:0]   block_number;
        logic [WIDX_W-1:0]  word_index;
        logic [WDATA_W-1:0] word_data;
        logic [GIDX_W-1:0]  group_index;
        logic [BLK_W-1:0]   count_value;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BLK_W-1:0]    allocated_block;
        logic [BLK_W-1:0]    free_total;
    } rsp_t;

endpackage

// ===== hw/rtl/gbba_chan_if.sv =====
// Valid/ready channel carrying one item of a packed payload type.
// Payload types come from gbba_pkg at the point of instantiation.
interface gbba_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/gbba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on gbba_pkg for default sizes only.
module gbba_ram #(
    parameter int WIDTH = gbba_pkg::WORD_BITS_DEF,
    parameter int DEPTH = gbba_pkg::STORE_WORDS_DEF
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== hw/rtl/grouped_block_bitmap_allocator.sv =====
// Top level of the grouped block bitmap allocator: sequencer, counts and scan datapath.
// Depends on gbba_pkg, gbba_chan_if, gbba_ram and the assertion macro header.
`include "grouped_block_bitmap_allocator_macros.svh"

// Block allocator over a first-fit used/free bitmap split into block groups.
// The bitmap lives in one RAM of MAX_GROUPS * MAX_GROUP_BITS / WORD_BITS words
// (group g owns a fixed slice of MAX_GROUP_BITS / WORD_BITS words, bit i of
// a group at word i / WORD_BITS, bit i mod WORD_BITS, set = used). Per-group
// free counts and the total free count sit in flip-flops. One request item
// gives exactly one response item: status, the granted block (zero unless an
// alloc succeeded) and the total free count after the item. Alloc walks the
// groups in order, skips groups whose count is zero or that hold no data
// blocks, and scans the group's words one per cycle through the RAM read
// port, masking bits past the group's size; the lowest clear bit is set
// with a read-modify-write. Free splits (block - first_data_block) into
// group and bit by repeated subtraction of blocks_per_group on the shared
// adder, one group per cycle, then clears the bit. A new item is accepted
// only while idle, after the previous response has been posted. After
// reset the block clears all MAX_GROUPS * MAX_GROUP_BITS / WORD_BITS words
// of the bitmap RAM (4096 at the defaults), one word per cycle, before it
// takes its first item; configuration writes are taken at any time but
// belong in idle periods. WORD_BITS and MAX_GROUP_BITS are powers of two.
module grouped_block_bitmap_allocator #(
    parameter int MAX_GROUPS     = gbba_pkg::MAX_GROUPS_DEF,
    parameter int MAX_GROUP_BITS = gbba_pkg::MAX_GROUP_BITS_DEF,
    parameter int WORD_BITS      = gbba_pkg::WORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [gbba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gbba_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    gbba_chan_if.sink                         request,
    gbba_chan_if.source                       response
);
    localparam int BLK_W       = gbba_pkg::BLK_W;
    localparam int GF_W        = gbba_pkg::GF_W;
    localparam int GROUP_WORDS = MAX_GROUP_BITS / WORD_BITS;
    localparam int STORE_WORDS = MAX_GROUPS * GROUP_WORDS;
    localparam int ADDR_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int WB_W        = $clog2(WORD_BITS);
    localparam int OFF_W       = $clog2(MAX_GROUP_BITS + 1);
    localparam int GRP_W       = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int GCNT_W      = $clog2(MAX_GROUPS + 1);
    localparam int BASE_W      = $clog2(MAX_GROUPS * MAX_GROUP_BITS + 1);
    localparam int SUM_W       = (BASE_W > BLK_W) ? BASE_W : BLK_W;

    // Lowest-bit one-hot to index
    function automatic logic [WB_W-1:0] onehot_index(input logic [WORD_BITS-1:0] v);
        logic [WB_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            idx = idx | (v[i] ? WB_W'(i) : WB_W'(0));
        end
        return idx;
    endfunction

    // ---------------- configuration registers ----------------
    logic                             fdb_reg;
    logic [gbba_pkg::BPG_CFG_W-1:0]   bpg_reg;
    logic [gbba_pkg::GC_CFG_W-1:0]    gc_reg;
    logic [BLK_W-1:0]                 tb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fdb_reg <= gbba_pkg::FDB_RST;
            bpg_reg <= gbba_pkg::BPG_RST;
            gc_reg  <= gbba_pkg::GC_RST;
            tb_reg  <= gbba_pkg::TB_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (gbba_pkg::cfg_idx_t'(cfg_index))
                gbba_pkg::CFG_FIRST_DATA_BLOCK: fdb_reg <= cfg_wdata[0];
                gbba_pkg::CFG_BLOCKS_PER_GROUP: bpg_reg <= cfg_wdata[gbba_pkg::BPG_CFG_W-1:0];
                gbba_pkg::CFG_GROUP_COUNT:      gc_reg  <= cfg_wdata[gbba_pkg::GC_CFG_W-1:0];
                gbba_pkg::CFG_TOTAL_BLOCKS:     tb_reg  <= cfg_wdata[BLK_W-1:0];
                default:                        fdb_reg <= fdb_reg;
            endcase
        end
    end

    // Effective geometry: clamped group size and group count, data span
    logic [OFF_W-1:0]  bpg_eff;
    logic [GCNT_W-1:0] ng;
    logic [BLK_W-1:0]  data_blocks;

    assign bpg_eff = (32'(bpg_reg) > MAX_GROUP_BITS) ? OFF_W'(MAX_GROUP_BITS) : OFF_W'(bpg_reg);
    assign ng      = (32'(gc_reg) > MAX_GROUPS) ? GCNT_W'(MAX_GROUPS) : GCNT_W'(gc_reg);
    assign data_blocks = (tb_reg > BLK_W'(fdb_reg)) ? (tb_reg - BLK_W'(fdb_reg)) : '0;

    // ---------------- state ----------------
    gbba_pkg::state_t  state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              out_valid_reg, out_valid_next;
    gbba_pkg::rsp_t    out_data_reg, out_data_next;

    gbba_pkg::req_t    item_reg, item_next;
    logic [GCNT_W-1:0] g_reg, g_next;
    logic [SUM_W-1:0]  base_reg, base_next;
    logic [ADDR_W-1:0] gaddr_reg, gaddr_next;
    logic [ADDR_W-1:0] word_addr_reg, word_addr_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    logic [OFF_W-1:0]  lim_reg, lim_next;
    logic [OFF_W-1:0]  pos_reg, pos_next;
    logic [BLK_W-1:0]  rem_reg, rem_next;
    gbba_pkg::status_t status_reg, status_next;
    logic [BLK_W-1:0]  granted_reg, granted_next;

    logic [GF_W-1:0]   gfree_reg [MAX_GROUPS];
    logic [BLK_W-1:0]  total_free_reg, total_free_next;
    logic              gf_we;
    logic [GRP_W-1:0]  gf_idx;
    logic [GF_W-1:0]   gf_wval;

    // RAM port signals
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    gbba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (STORE_WORDS)
    ) u_bitmap (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // ---------------- shared adder ----------------
    // base + bpg on group advance, rem - bpg on the free division step,
    // base + pos + first_data_block when forming the granted block.
    logic [SUM_W-1:0] au_a, au_b;
    logic             au_sub, au_cin;
    logic [SUM_W:0]   au_res;

    always_comb
    begin
        au_a   = base_reg;
        au_b   = SUM_W'(bpg_eff);
        au_sub = 1'b0;
        au_cin = 1'b0;
        unique case (state_reg)
            gbba_pkg::ST_F_DIV:
            begin
                au_a   = SUM_W'(rem_reg);
                au_sub = 1'b1;
                au_cin = 1'b1;
            end
            gbba_pkg::ST_A_GRANT:
            begin
                au_b   = SUM_W'(pos_reg);
                au_cin = fdb_reg;
            end
            default:
            begin
                au_sub = 1'b0;
            end
        endcase
    end

    assign au_res = {1'b0, au_a} + {1'b0, (au_sub ? ~au_b : au_b)} + (SUM_W + 1)'(au_cin);

    // ---------------- scan / decode conditions ----------------
    gbba_pkg::cmd_t       item_cmd;
    logic [GF_W-1:0]      gfree_cur;
    logic [SUM_W-1:0]     data_ext, bpg_ext, left_blocks, lim_wide;
    logic [OFF_W-1:0]     lim_calc;
    logic [OFF_W-1:0]     remaining, off_inc;
    logic [WORD_BITS-1:0] avail_mask, free_vec, low_bit;
    logic [ADDR_W-1:0]    free_addr;
    logic                 req_fire, out_free, grp_over, grp_skip;
    logic                 chk_found, chk_last, div_fit, free_bad;

    assign item_cmd  = gbba_pkg::cmd_t'(item_reg.cmd);
    assign gfree_cur = gfree_reg[g_reg[GRP_W-1:0]];

    assign data_ext    = SUM_W'(data_blocks);
    assign bpg_ext     = SUM_W'(bpg_eff);
    assign left_blocks = data_ext - base_reg;
    assign lim_wide    = (base_reg >= data_ext) ? '0 :
                         ((left_blocks < bpg_ext) ? left_blocks : bpg_ext);
    assign lim_calc    = OFF_W'(lim_wide);

    // Bits of this word that still lie inside the group
    assign remaining  = lim_reg - off_reg;
    assign off_inc    = off_reg + OFF_W'(WORD_BITS);
    assign avail_mask = (remaining >= OFF_W'(WORD_BITS)) ? '1 :
                        ((WORD_BITS'(1) << remaining) - WORD_BITS'(1));
    assign free_vec   = ~ram_rdata & avail_mask;
    assign low_bit    = free_vec & (~free_vec + WORD_BITS'(1));

    assign free_addr  = gaddr_reg + ADDR_W'(rem_reg >> WB_W);

    assign req_fire  = request.valid && request.ready;
    assign out_free  = !out_valid_reg || response.ready;
    assign grp_over  = (g_reg >= ng);
    assign grp_skip  = (gfree_cur == '0) || (lim_calc == '0);
    assign chk_found = |free_vec;
    assign chk_last  = (off_inc >= lim_reg);
    assign div_fit   = !au_res[SUM_W];
    assign free_bad  = (item_reg.block_number < BLK_W'(fdb_reg)) || (bpg_eff == '0);

    assign request.ready  = (state_reg == gbba_pkg::ST_IDLE);
    assign response.valid = out_valid_reg;
    assign response.data  = out_data_reg;

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gbba_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == ADDR_W'(STORE_WORDS - 1))
                begin
                    state_next = gbba_pkg::ST_IDLE;
                end
            end
            gbba_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = gbba_pkg::ST_EXEC;
                end
            end
            gbba_pkg::ST_EXEC:
            begin
                unique case (item_cmd)
                    gbba_pkg::CMD_ALLOC: state_next = gbba_pkg::ST_A_GRP;
                    gbba_pkg::CMD_FREE:
                        state_next = free_bad ? gbba_pkg::ST_DONE : gbba_pkg::ST_F_DIV;
                    default:             state_next = gbba_pkg::ST_DONE;
                endcase
            end
            gbba_pkg::ST_A_GRP:
            begin
                if (grp_over)
                begin
                    state_next = gbba_pkg::ST_DONE;
                end
                else if (!grp_skip)
                begin
                    state_next = gbba_pkg::ST_A_CHK;
                end
            end
            gbba_pkg::ST_A_CHK:
            begin
                if (chk_found)
                begin
                    state_next = gbba_pkg::ST_A_GRANT;
                end
                else if (chk_last)
                begin
                    state_next = gbba_pkg::ST_A_GRP;
                end
            end
            gbba_pkg::ST_A_GRANT:
            begin
                state_next = gbba_pkg::ST_DONE;
            end
            gbba_pkg::ST_F_DIV:
            begin
                if (grp_over)
                begin
                    state_next = gbba_pkg::ST_DONE;
                end
                else if (div_fit)
                begin
                    state_next = gbba_pkg::ST_F_WR;
                end
            end
            gbba_pkg::ST_F_WR:
            begin
                state_next = gbba_pkg::ST_DONE;
            end
            gbba_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = gbba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gbba_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------- datapath and outputs ----------------
    always_comb
    begin
        clr_cnt_next    = clr_cnt_reg;
        out_valid_next  = out_valid_reg && !response.ready;
        out_data_next   = out_data_reg;
        item_next       = item_reg;
        g_next          = g_reg;
        base_next       = base_reg;
        gaddr_next      = gaddr_reg;
        word_addr_next  = word_addr_reg;
        off_next        = off_reg;
        lim_next        = lim_reg;
        pos_next        = pos_reg;
        rem_next        = rem_reg;
        status_next     = status_reg;
        granted_next    = granted_reg;
        total_free_next = total_free_reg;
        gf_we           = 1'b0;
        gf_idx          = g_reg[GRP_W-1:0];
        gf_wval         = gfree_cur;
        ram_we          = 1'b0;
        ram_waddr       = word_addr_reg;
        ram_wdata       = ram_rdata;
        ram_raddr       = word_addr_reg;

        unique case (state_reg)
            gbba_pkg::ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
            end
            gbba_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    item_next = request.data;
                end
            end
            gbba_pkg::ST_EXEC:
            begin
                status_next  = gbba_pkg::STAT_OK;
                granted_next = '0;
                g_next       = '0;
                base_next    = '0;
                gaddr_next   = '0;
                unique case (item_cmd)
                    gbba_pkg::CMD_ALLOC:
                    begin
                        status_next = gbba_pkg::STAT_OK;
                    end
                    gbba_pkg::CMD_FREE:
                    begin
                        if (free_bad)
                        begin
                            status_next = gbba_pkg::STAT_INVALID;
                        end
                        rem_next = item_reg.block_number - BLK_W'(fdb_reg);
                    end
                    gbba_pkg::CMD_LOAD_WORD:
                    begin
                        // words past the store are dropped
                        if (32'(item_reg.word_index) < STORE_WORDS)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = ADDR_W'(item_reg.word_index);
                            ram_wdata = WORD_BITS'(item_reg.word_data);
                        end
                    end
                    gbba_pkg::CMD_LOAD_GROUP:
                    begin
                        if (32'(item_reg.group_index) < MAX_GROUPS)
                        begin
                            gf_we   = 1'b1;
                            gf_idx  = GRP_W'(item_reg.group_index);
                            gf_wval = (item_reg.count_value > BLK_W'(gbba_pkg::GFREE_MAX)) ?
                                      gbba_pkg::GFREE_MAX : item_reg.count_value[GF_W-1:0];
                        end
                    end
                    gbba_pkg::CMD_LOAD_TOTAL:
                    begin
                        total_free_next = item_reg.count_value;
                    end
                    default:
                    begin
                        status_next = gbba_pkg::STAT_OK;
                    end
                endcase
            end
            gbba_pkg::ST_A_GRP:
            begin
                ram_raddr      = gaddr_reg;
                word_addr_next = gaddr_reg;
                lim_next       = lim_calc;
                off_next       = '0;
                if (grp_over)
                begin
                    status_next = gbba_pkg::STAT_NO_SPACE;
                end
                else if (grp_skip)
                begin
                    g_next     = g_reg + GCNT_W'(1);
                    base_next  = au_res[SUM_W-1:0];
                    gaddr_next = gaddr_reg + ADDR_W'(GROUP_WORDS);
                end
            end
            gbba_pkg::ST_A_CHK:
            begin
                if (chk_found)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = word_addr_reg;
                    ram_wdata = ram_rdata | low_bit;
                    gf_we     = 1'b1;
                    gf_wval   = gfree_cur - GF_W'(1);
                    if (total_free_reg != '0)
                    begin
                        total_free_next = total_free_reg - BLK_W'(1);
                    end
                    pos_next = off_reg | OFF_W'(onehot_index(low_bit));
                end
                else if (chk_last)
                begin
                    g_next     = g_reg + GCNT_W'(1);
                    base_next  = au_res[SUM_W-1:0];
                    gaddr_next = gaddr_reg + ADDR_W'(GROUP_WORDS);
                end
                else
                begin
                    off_next       = off_inc;
                    word_addr_next = word_addr_reg + ADDR_W'(1);
                    ram_raddr      = word_addr_reg + ADDR_W'(1);
                end
            end
            gbba_pkg::ST_A_GRANT:
            begin
                granted_next = au_res[BLK_W-1:0];
            end
            gbba_pkg::ST_F_DIV:
            begin
                ram_raddr      = free_addr;
                word_addr_next = free_addr;
                if (grp_over)
                begin
                    status_next = gbba_pkg::STAT_INVALID;
                end
                else if (!div_fit)
                begin
                    rem_next   = au_res[BLK_W-1:0];
                    g_next     = g_reg + GCNT_W'(1);
                    gaddr_next = gaddr_reg + ADDR_W'(GROUP_WORDS);
                end
            end
            gbba_pkg::ST_F_WR:
            begin
                // double frees are not caught: the counts still rise
                ram_we    = 1'b1;
                ram_waddr = word_addr_reg;
                ram_wdata = ram_rdata & ~(WORD_BITS'(1) << rem_reg[WB_W-1:0]);
                gf_we     = 1'b1;
                gf_wval   = (gfree_cur != gbba_pkg::GFREE_MAX) ?
                            (gfree_cur + GF_W'(1)) : gfree_cur;
                if (total_free_reg != gbba_pkg::TOTAL_MAX)
                begin
                    total_free_next = total_free_reg + BLK_W'(1);
                end
            end
            gbba_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next                = 1'b1;
                    out_data_next.status          = status_reg;
                    out_data_next.allocated_block = granted_reg;
                    out_data_next.free_total      = total_free_reg;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= gbba_pkg::ST_CLEAR;
            clr_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
            total_free_reg <= '0;
            for (int i = 0; i < MAX_GROUPS; i++)
            begin
                gfree_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            out_valid_reg  <= out_valid_next;
            total_free_reg <= total_free_next;
            if (gf_we)
            begin
                gfree_reg[gf_idx] <= gf_wval;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        item_reg      <= item_next;
        g_reg         <= g_next;
        base_reg      <= base_next;
        gaddr_reg     <= gaddr_next;
        word_addr_reg <= word_addr_next;
        off_reg       <= off_next;
        lim_reg       <= lim_next;
        pos_reg       <= pos_next;
        rem_reg       <= rem_next;
        status_reg    <= status_next;
        granted_reg   <= granted_next;
    end

    // ---------------- checks ----------------
    `GBBA_ASSERT_NEXT(a_accept_leaves_idle, req_fire,
        state_reg != gbba_pkg::ST_IDLE, "accepted item did not start the sequencer")
    `GBBA_ASSERT_NOW(a_no_ram_write_idle, state_reg == gbba_pkg::ST_IDLE,
        !ram_we, "bitmap written while idle")
    `GBBA_ASSERT_NOW(a_scan_inside_group, state_reg == gbba_pkg::ST_A_CHK,
        off_reg < lim_reg, "word scan ran past the group size")
    `GBBA_ASSERT_NOW(a_free_bit_in_group, state_reg == gbba_pkg::ST_F_WR,
        SUM_W'(rem_reg) < SUM_W'(bpg_eff), "free bit index not below the group size")
    `GBBA_ASSERT_NEXT(a_done_posts_result, state_reg == gbba_pkg::ST_DONE && out_free,
        out_valid_reg, "finished item not posted to the response register")

endmodule
